### design/sit_pkg.sv
// Shared types and constants for the segment intersection test core.
// No dependencies; the request channel interface and the core use it.
`default_nettype none

package sit_pkg;

   // Width of every coordinate field on the request channel.
   localparam int FIELD_WIDTH = 16;

   // Sign of one cross product, kept as two flags.
   typedef struct packed {
      logic neg;
      logic zero;
   } orient_type;

endpackage

`default_nettype wire

### design/sit_req_if.sv
// Request channel of the segment intersection test core: valid/ready plus two segments.
// Depends on sit_pkg for the coordinate field width.
`default_nettype none

interface sit_req_if;
   logic                             valid;
   logic                             ready;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_a_start_x;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_a_start_y;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_a_end_x;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_a_end_y;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_b_start_x;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_b_start_y;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_b_end_x;
   logic [sit_pkg::FIELD_WIDTH-1:0]  seg_b_end_y;

   modport source (
      output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
             seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
      input  ready
   );

   modport sink (
      input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
             seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
      output ready
   );
endinterface

`default_nettype wire

### design/sit_rsp_if.sv
// Response channel of the segment intersection test core: valid/ready plus the verdict.
// No dependencies.
`default_nettype none

interface sit_rsp_if;
   logic valid;
   logic ready;
   logic intersects;

   modport source (output valid, intersects, input ready);
   modport sink   (input valid, intersects, output ready);
endinterface

`default_nettype wire

### design/segment_intersection_test_core.sv
// Segment intersection test core: four-stage pipeline of orientation tests.
// Depends on sit_pkg, sit_req_if and sit_rsp_if.
//
// Usage
// Each request on req_bus carries two closed segments, A and B, as four
// endpoints with two's complement coordinates. Each coordinate is taken as
// its low COORD_WIDTH bits, sign extended (zero extended past the field
// width when COORD_WIDTH is wider than the field). Exactly one response
// comes back on rsp_bus per request, in request order, with intersects set
// when the segments share at least one point.
// Pipeline: a request reaches rsp_bus.valid through four register stages:
// differences and bounding-box compares, the eight products, the four
// subtractions with their signs, and the output register.
// Throughput is one request per cycle while rsp_bus.ready stays high; the
// eight multipliers set the critical path of the product stage.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles collapse and a stalled receiver holds
// the result in the output register while the earlier stages keep filling.
// Once all four stages are full and rsp_bus.ready is low, req_bus.ready
// drops. Synchronous reset clears the valid bits; payload is not reset.
`default_nettype none

module segment_intersection_test_core #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sit_req_if.sink    req_bus,
   sit_rsp_if.source  rsp_bus
);

   // Coordinate, difference, product and cross product widths.
   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int FW = sit_pkg::FIELD_WIDTH;

   // Low CW bits of a field as a signed coordinate. Going through a word
   // wide enough for both sides handles CW above and below the field width.
   function automatic logic signed [CW-1:0] to_coord(input logic [FW-1:0] raw);
      logic [CW+FW-1:0] wide;
      wide = (CW+FW)'(raw);
      return signed'(wide[CW-1:0]);
   endfunction

   // Point c lies in the bounding box of a and b, one axis at a time.
   function automatic logic in_span(input logic signed [CW-1:0] a,
                                    input logic signed [CW-1:0] b,
                                    input logic signed [CW-1:0] c);
      return (a >= c || b >= c) && (a <= c || b <= c);
   endfunction

   // Sign flags of one cross product.
   function automatic sit_pkg::orient_type sign_of(input logic signed [SW-1:0] v);
      sit_pkg::orient_type o;
      o.neg  = v[SW-1];
      o.zero = (v == '0);
      return o;
   endfunction

   // Stage handshakes: each stage loads when it is empty or its successor moves.
   logic rdy1, rdy2, rdy3, rdy4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign rdy4 = !v4_ff || rsp_bus.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_bus.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_bus.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: coordinates, the twelve differences and the box compares.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

   assign ax1 = to_coord(req_bus.seg_a_start_x);
   assign ay1 = to_coord(req_bus.seg_a_start_y);
   assign ax2 = to_coord(req_bus.seg_a_end_x);
   assign ay2 = to_coord(req_bus.seg_a_end_y);
   assign bx1 = to_coord(req_bus.seg_b_start_x);
   assign by1 = to_coord(req_bus.seg_b_start_y);
   assign bx2 = to_coord(req_bus.seg_b_end_x);
   assign by2 = to_coord(req_bus.seg_b_end_y);

   // Direction of each segment, and offsets from the end of one segment to the other's endpoints.
   logic signed [DW-1:0] dax_in, day_in, dbx_in, dby_in;
   logic signed [DW-1:0] e1x_in, e1y_in, e2x_in, e2y_in;
   logic signed [DW-1:0] e3x_in, e3y_in, e4x_in, e4y_in;
   logic signed [DW-1:0] dax_ff, day_ff, dbx_ff, dby_ff;
   logic signed [DW-1:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [DW-1:0] e3x_ff, e3y_ff, e4x_ff, e4y_ff;
   logic [3:0]           box_in, box1_ff, box2_ff, box3_ff;

   always_comb begin
      dax_in = DW'(ax2) - DW'(ax1);
      day_in = DW'(ay2) - DW'(ay1);
      dbx_in = DW'(bx2) - DW'(bx1);
      dby_in = DW'(by2) - DW'(by1);
      e1x_in = DW'(bx1) - DW'(ax2);
      e1y_in = DW'(by1) - DW'(ay2);
      e2x_in = DW'(bx2) - DW'(ax2);
      e2y_in = DW'(by2) - DW'(ay2);
      e3x_in = DW'(ax1) - DW'(bx2);
      e3y_in = DW'(ay1) - DW'(by2);
      e4x_in = DW'(ax2) - DW'(bx2);
      e4y_in = DW'(ay2) - DW'(by2);
      // Bit 0: B start in box of A; bit 1: B end in box of A;
      // bit 2: A start in box of B; bit 3: A end in box of B.
      box_in[0] = in_span(ax1, ax2, bx1) && in_span(ay1, ay2, by1);
      box_in[1] = in_span(ax1, ax2, bx2) && in_span(ay1, ay2, by2);
      box_in[2] = in_span(bx1, bx2, ax1) && in_span(by1, by2, ay1);
      box_in[3] = in_span(bx1, bx2, ax2) && in_span(by1, by2, ay2);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dax_ff  <= dax_in;
         day_ff  <= day_in;
         dbx_ff  <= dbx_in;
         dby_ff  <= dby_in;
         e1x_ff  <= e1x_in;
         e1y_ff  <= e1y_in;
         e2x_ff  <= e2x_in;
         e2y_ff  <= e2y_in;
         e3x_ff  <= e3x_in;
         e3y_ff  <= e3y_in;
         e4x_ff  <= e4x_in;
         e4y_ff  <= e4y_in;
         box1_ff <= box_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the two products of each cross product. Every product is
   // exact in PW bits.
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] p1a_ff, p1b_ff, p2a_ff, p2b_ff;
   logic signed [PW-1:0] p3a_ff, p3b_ff, p4a_ff, p4b_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         p1a_ff  <= PW'(day_ff) * PW'(e1x_ff);
         p1b_ff  <= PW'(dax_ff) * PW'(e1y_ff);
         p2a_ff  <= PW'(day_ff) * PW'(e2x_ff);
         p2b_ff  <= PW'(dax_ff) * PW'(e2y_ff);
         p3a_ff  <= PW'(dby_ff) * PW'(e3x_ff);
         p3b_ff  <= PW'(dbx_ff) * PW'(e3y_ff);
         p4a_ff  <= PW'(dby_ff) * PW'(e4x_ff);
         p4b_ff  <= PW'(dbx_ff) * PW'(e4y_ff);
         box2_ff <= box1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: subtract and keep only the sign of each cross product.
   // ---------------------------------------------------------------------
   sit_pkg::orient_type o1_ff, o2_ff, o3_ff, o4_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         o1_ff   <= sign_of(SW'(p1a_ff) - SW'(p1b_ff));
         o2_ff   <= sign_of(SW'(p2a_ff) - SW'(p2b_ff));
         o3_ff   <= sign_of(SW'(p3a_ff) - SW'(p3b_ff));
         o4_ff   <= sign_of(SW'(p4a_ff) - SW'(p4b_ff));
         box3_ff <= box2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: the decision, held in the output register. The segments
   // cross when each one's endpoints lie on different sides of the other;
   // otherwise a collinear endpoint inside the other's box is a touch.
   // ---------------------------------------------------------------------
   logic hit_in, hit_ff;

   always_comb begin
      hit_in = ((o1_ff != o2_ff) && (o3_ff != o4_ff))
            || (o1_ff.zero && box3_ff[0])
            || (o2_ff.zero && box3_ff[1])
            || (o3_ff.zero && box3_ff[2])
            || (o4_ff.zero && box3_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (rdy4) hit_ff <= hit_in;
   end

   assign rsp_bus.valid      = v4_ff;
   assign rsp_bus.intersects = hit_ff;

`ifndef NO_ASSERTIONS
   // The request side only backs up once every stage holds a request
   // and the receiver is stalling.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready == !(v1_ff && v2_ff && v3_ff && v4_ff && !rsp_bus.ready))
      else $error("request ready does not match pipeline occupancy");

   // Reset empties the pipeline, so no response follows it.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

   // When segment B lies strictly on one side of A's line, no touch.
   a_one_side_no_hit: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !o1_ff.zero && !o2_ff.zero && (o1_ff.neg == o2_ff.neg)) |-> !hit_in)
      else $error("hit reported with segment B on one side of segment A");

   // A response taken while stage 3 was empty leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !v3_ff) |=> !rsp_bus.valid)
      else $error("response repeated after being taken");
`endif

endmodule

`default_nettype wire
